@@ src/esd_pkg.sv @@
// shared types and helpers for the escape sequence utf-8 decoder
// result group carried from the decoder to the output queue, utf-8 encoder
// no dependencies
package esd_pkg;

	// most bytes one input beat can cause: four utf-8 bytes plus one plain byte
	localparam int GRP_BYTES = 5;
	localparam int GRP_CNT_W = $clog2(GRP_BYTES + 1);

	// result groups held between decoder and output
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	localparam logic [23:0] UTF8_MAX1 = 24'h00007f;
	localparam logic [23:0] UTF8_MAX2 = 24'h0007ff;
	localparam logic [23:0] UTF8_MAX3 = 24'h00ffff;
	localparam logic [23:0] UTF8_MAX4 = 24'h10ffff;

	typedef struct packed {
		logic [GRP_CNT_W-1:0]       cnt;    // number of result beats, 1..GRP_BYTES
		logic [GRP_BYTES-1:0][7:0]  bytes;
		logic                       has;    // 0 for the empty closing beat
		logic                       last;   // group closes the literal
	} group_t;

	typedef struct packed {
		logic [2:0]      cnt;
		logic [3:0][7:0] b;
	} utf8_t;

	function automatic utf8_t utf8_encode(input logic [23:0] v);
		utf8_t r;
		r.cnt = 3'd0;
		r.b   = '0;
		if (v <= UTF8_MAX1) begin
			r.cnt  = 3'd1;
			r.b[0] = v[7:0];
		end else if (v <= UTF8_MAX2) begin
			r.cnt  = 3'd2;
			r.b[0] = {3'b110, v[10:6]};
			r.b[1] = {2'b10, v[5:0]};
		end else if (v <= UTF8_MAX3) begin
			r.cnt  = 3'd3;
			r.b[0] = {4'b1110, v[15:12]};
			r.b[1] = {2'b10, v[11:6]};
			r.b[2] = {2'b10, v[5:0]};
		end else if (v <= UTF8_MAX4) begin
			r.cnt  = 3'd4;
			r.b[0] = {5'b11110, v[20:18]};
			r.b[1] = {2'b10, v[17:12]};
			r.b[2] = {2'b10, v[11:6]};
			r.b[3] = {2'b10, v[5:0]};
		end
		return r;
	endfunction

endpackage

@@ src/esd_decode.sv @@
// escape decoder: mode, digit count and code value registers, and the logic
// that turns one input beat into a group of result bytes
// depends on esd_pkg
module esd_decode import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output group_t     grp
);

	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_ESC   = 2'd1;
	localparam logic [1:0] MODE_HEX   = 2'd2;

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] CH_U_LO   = 8'h75;
	localparam logic [7:0] CH_U_UP   = 8'h55;

	logic [1:0]  mode_q, mode_d;
	logic [2:0]  digits_q, digits_d;
	logic [23:0] acc_q, acc_d;

	logic        is_hex;
	logic [3:0]  hex_val;
	logic [23:0] acc_shift;
	logic [2:0]  digits_dec;
	logic        u_en;
	logic [23:0] u_val;
	utf8_t       u;
	logic        t_en;
	logic [7:0]  t_byte;
	logic [GRP_CNT_W-1:0] n;

	always_comb begin
		is_hex  = 1'b1;
		hex_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			hex_val = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			hex_val = 4'(in_byte - 8'h37);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			hex_val = 4'(in_byte - 8'h57);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign acc_shift  = {acc_q[19:0], hex_val};
	assign digits_dec = digits_q - 3'd1;

	always_comb begin
		mode_d   = MODE_PLAIN;
		digits_d = digits_q;
		acc_d    = acc_q;
		u_en     = 1'b0;
		u_val    = acc_q;
		t_en     = 1'b0;
		t_byte   = in_byte;
		unique case (mode_q)
			MODE_ESC: begin
				t_en = 1'b1;
				unique case (in_byte)
					CH_A:      t_byte = 8'h07;
					CH_B:      t_byte = 8'h08;
					CH_E:      t_byte = 8'h1b;
					CH_F:      t_byte = 8'h0c;
					CH_N:      t_byte = 8'h0a;
					CH_R:      t_byte = 8'h0d;
					CH_T:      t_byte = 8'h09;
					CH_V:      t_byte = 8'h0b;
					CH_ZERO:   t_byte = 8'h00;
					CH_X, CH_U_LO, CH_U_UP: begin
						// hex escape; ending here gives value 0, one nul byte
						acc_d  = '0;
						t_en   = in_last;
						t_byte = 8'h00;
						if (!in_last) begin
							mode_d = MODE_HEX;
						end
						unique case (in_byte)
							CH_X:    digits_d = 3'd2;
							CH_U_LO: digits_d = 3'd4;
							default: digits_d = 3'd6;
						endcase
					end
					default:   t_byte = in_byte;
				endcase
			end
			MODE_HEX: begin
				if (is_hex) begin
					acc_d    = acc_shift;
					digits_d = digits_dec;
					u_val    = acc_shift;
					if (digits_dec == 3'd0 || in_last) begin
						u_en = 1'b1;
					end else begin
						mode_d = MODE_HEX;
					end
				end else begin
					// flush gathered value, then treat the byte as plain
					u_en = 1'b1;
					if (in_byte == CH_BSLASH) begin
						t_en   = in_last;
						t_byte = 8'h00;
						if (!in_last) begin
							mode_d = MODE_ESC;
						end
					end else begin
						t_en = 1'b1;
					end
				end
			end
			default: begin
				if (in_byte == CH_BSLASH) begin
					t_en   = in_last;
					t_byte = 8'h00;
					if (!in_last) begin
						mode_d = MODE_ESC;
					end
				end else begin
					t_en = 1'b1;
				end
			end
		endcase
		if (in_last) begin
			mode_d   = MODE_PLAIN;
			digits_d = '0;
			acc_d    = '0;
		end
	end

	assign u = utf8_encode(u_val);

	always_comb begin
		logic [GRP_CNT_W-1:0] ucnt;
		ucnt = u_en ? GRP_CNT_W'(u.cnt) : '0;
		n    = ucnt + GRP_CNT_W'(t_en);
		for (int i = 0; i < GRP_BYTES; i++) begin
			if (i < 4 && GRP_CNT_W'(i) < ucnt) begin
				grp.bytes[i] = u.b[i % 4];
			end else if (GRP_CNT_W'(i) == ucnt && t_en) begin
				grp.bytes[i] = t_byte;
			end else begin
				grp.bytes[i] = 8'h00;
			end
		end
		grp.has  = (n != '0);
		grp.cnt  = (n != '0) ? n : GRP_CNT_W'(1);
		grp.last = in_last;
		push     = accept && ((n != '0) || in_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			digits_q <= '0;
			acc_q    <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			digits_q <= digits_d;
			acc_q    <= acc_d;
		end
	end

endmodule

@@ src/esd_queue.sv @@
// result group queue and output serializer, one byte per beat
// depends on esd_pkg
module esd_queue import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  group_t     push_grp,
	output logic       full,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_end,
	output logic       string_end
);

	group_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic [GRP_CNT_W-1:0] idx_q;

	group_t head;
	logic   beat;
	logic   pop;

	assign head      = slots_q[rd_ptr_q];
	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign out_byte  = head.bytes[idx_q];
	assign has_byte  = head.has;
	assign run_end   = (idx_q == head.cnt - GRP_CNT_W'(1));
	assign string_end = run_end && head.last;

	assign beat = out_valid && !out_stall;
	assign pop  = beat && run_end;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			idx_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
				idx_q    <= '0;
			end else if (beat) begin
				idx_q <= idx_q + GRP_CNT_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < head.cnt))
		else $error("byte index past end of group");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_empty_beat_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !has_byte) |-> (run_end && string_end))
		else $error("empty beat not closing the literal");

endmodule

@@ src/escape_sequence_utf8_decoder.sv @@
// top level of the backslash escape decoder with utf-8 output
// depends on esd_pkg, esd_decode, esd_queue
// Decodes a string literal one byte per beat. Each input beat that gives bytes
// is decoded combinationally into a group of 1 to 5 result bytes (an escape
// value gathered from x, u or U becomes 1 to 4 utf-8 bytes, or none above
// 10ffff) that is written to a four-group queue; the output side sends one
// byte per beat. Inputs are taken every cycle while the queue has room, so
// plain text flows at one byte per cycle while the output does not stall, and
// only output stalls or long runs of multi-byte groups slow the input to the
// output byte rate. A final byte that gives no bytes yields one empty beat
// with has_byte low that carries run_end and string_end.
module escape_sequence_utf8_decoder import esd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       run_end,
	output logic       string_end
);

	logic   accept;
	logic   push;
	logic   full;
	group_t grp;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	esd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_byte),
		.in_last (in_last),
		.push    (push),
		.grp     (grp)
	);

	esd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_grp   (grp),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule
